// ===== rtl/core/rma_pkg.sv =====
// rma_pkg: shared constants, types and helper functions of the register map allocator
// no dependencies; used by the interfaces, the top level, the checker and the testbench
package rma_pkg;

  // size of the physical pool and of the map
  localparam int MAX_REGS = 32;
  localparam int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CNT_W    = $clog2(MAX_REGS + 1);

  // field widths fixed by the word format
  localparam int OP_W    = 1;
  localparam int VREG_W  = 32;
  localparam int PHYS_W  = 5;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;
  localparam int MASK_W  = 32;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = CFG_AW - 2;
  localparam logic [CFG_IW-1:0] REG_IDX_COUNT = '0;

  // opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_MAPPED = 2'd2;

  // one map entry as stored in the ram
  typedef struct packed {
    logic [VREG_W-1:0] virt;
    logic [IDX_W-1:0]  phys;
  } entry_t;

  // count in use: zero reads as one, anything above the pool as the pool size
  function automatic logic [CNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (cnt > COUNT_W'(MAX_REGS)) begin
      res = CNT_W'(MAX_REGS);
    end else begin
      res = CNT_W'(cnt);
    end
    return res;
  endfunction

  // low n bits set
  function automatic logic [MASK_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [MASK_W:0] wide;
    wide = ((MASK_W + 1)'(1) << n) - (MASK_W + 1)'(1);
    return wide[MASK_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rma_if.sv =====
// rma_in_if / rma_out_if: valid-ready channels for request and result words
// depends on rma_pkg for field widths
interface rma_in_if;
  import rma_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [VREG_W-1:0] vreg_num;

  modport source (output valid, output opcode, output vreg_num, input ready);
  modport sink   (input valid, input opcode, input vreg_num, output ready);
endinterface

interface rma_out_if;
  import rma_pkg::*;

  logic              valid;
  logic              ready;
  logic [PHYS_W-1:0] phys_reg;
  logic [STAT_W-1:0] status;

  modport source (output valid, output phys_reg, output status, input ready);
  modport sink   (input valid, input phys_reg, input status, output ready);
endinterface

// ===== rtl/core/rma_ram.sv =====
// rma_ram: generic single write port, single read port ram with registered read
// no dependencies
module rma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/register_map_allocator.sv =====
// register_map_allocator: virtual to physical register map with a free bitmap
// one word at a time: the input stays closed until the result enters the output register
// one compare unit walks the map ram, one entry a cycle, up to the first hit or the last entry in use
// reset: synchronous active-low rst_n sets count to 32, empties the map, marks all registers free
// a count write empties the map at once and frees the low eff_count(count) registers
// depends on rma_pkg, rma_if (channels) and rma_ram (map storage)
module register_map_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  rma_in_if.sink                     in_ch,
  rma_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rma_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rma_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rma_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import rma_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r;
  logic [VREG_W-1:0]  vreg_r;
  logic [CNT_W-1:0]   a_r;
  logic [IDX_W-1:0]   c_r;
  logic               pipe_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hidx_r;
  logic [IDX_W-1:0]   hphys_r;
  logic               slot_ok_r;
  logic [IDX_W-1:0]   slot_r;
  logic               free_ok_r;
  logic [IDX_W-1:0]   free_r;
  logic [MAX_REGS-1:0] valid_r;
  logic [MASK_W-1:0]  free_mask_r;
  logic [COUNT_W-1:0] pool_count_r;
  logic               out_valid_r;
  logic [PHYS_W-1:0]  out_phys_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [CNT_W-1:0]   n_eff;
  logic               in_acc;
  logic               issue;
  entry_t             rd_ent;
  entry_t             wr_ent;
  logic               cmp_go;
  logic               match;
  logic               last;
  logic               can_out;
  logic               finish_go;
  logic               do_alloc;
  logic               cfg_wr;
  logic [PHYS_W-1:0]  res_phys;
  logic [STAT_W-1:0]  res_status;

  // handshake and scan control
  assign n_eff     = eff_count(pool_count_r);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign issue     = (state_r == S_SCAN) && (a_r < n_eff);
  assign cmp_go    = (state_r == S_SCAN) && pipe_r;
  assign match     = cmp_go && valid_r[c_r] && (rd_ent.virt == vreg_r);
  assign last      = cmp_go && (CNT_W'(c_r) == (n_eff - CNT_W'(1)));
  assign can_out   = !out_valid_r || out_ch.ready;
  assign finish_go = (state_r == S_FINISH) && can_out;
  assign do_alloc  = (op_r == OP_ALLOC) && !hit_r && slot_ok_r && free_ok_r;

  // map storage, one entry read per cycle during the scan
  assign wr_ent.virt = vreg_r;
  assign wr_ent.phys = free_r;

  rma_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_REGS)
  ) u_map_ram (
    .clk   (clk),
    .we    (finish_go && do_alloc),
    .waddr (slot_r),
    .wdata (wr_ent),
    .raddr (a_r[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (match || last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (can_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result of the finished word
  always_comb begin
    res_phys   = '0;
    res_status = ST_OK;
    if (op_r == OP_ALLOC) begin
      if (hit_r) begin
        res_phys = PHYS_W'(hphys_r);
      end else if (do_alloc) begin
        res_phys = PHYS_W'(free_r);
      end else begin
        res_status = ST_NO_FREE;
      end
    end else begin
      if (hit_r) begin
        res_phys = PHYS_W'(hphys_r);
      end else begin
        res_status = ST_NOT_MAPPED;
      end
    end
  end

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1:2] == REG_IDX_COUNT);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_IDX_COUNT) ?
                      CFG_DW'(pool_count_r) : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pipe_r       <= 1'b0;
      a_r          <= '0;
      hit_r        <= 1'b0;
      slot_ok_r    <= 1'b0;
      free_ok_r    <= 1'b0;
      valid_r      <= '0;
      free_mask_r  <= low_mask(CNT_W'(MAX_REGS));
      pool_count_r <= COUNT_W'(MAX_REGS);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // new word starts a fresh scan
      if (in_acc) begin
        a_r       <= '0;
        pipe_r    <= 1'b0;
        hit_r     <= 1'b0;
        slot_ok_r <= 1'b0;
        free_ok_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (issue) begin
          a_r <= a_r + CNT_W'(1);
        end
        pipe_r <= issue;
        if (match) begin
          hit_r <= 1'b1;
        end else if (cmp_go) begin
          if (!valid_r[c_r]) slot_ok_r <= 1'b1;
          if (free_mask_r[c_r]) free_ok_r <= 1'b1;
        end
      end

      // commit map update and hand the word to the output register
      if (finish_go) begin
        out_valid_r <= 1'b1;
        if (do_alloc) begin
          valid_r[slot_r]     <= 1'b1;
          free_mask_r[free_r] <= 1'b0;
        end else if (op_r == OP_FREE && hit_r) begin
          valid_r[hidx_r]      <= 1'b0;
          free_mask_r[hphys_r] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // count write empties the map
      if (cfg_wr) begin
        pool_count_r <= cfg_pwdata[COUNT_W-1:0];
        valid_r      <= '0;
        free_mask_r  <= low_mask(eff_count(cfg_pwdata[COUNT_W-1:0]));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.opcode;
      vreg_r <= in_ch.vreg_num;
    end
    if (issue) begin
      c_r <= a_r[IDX_W-1:0];
    end
    if (match) begin
      hidx_r  <= c_r;
      hphys_r <= rd_ent.phys;
    end else if (cmp_go) begin
      if (!valid_r[c_r] && !slot_ok_r) slot_r <= c_r;
      if (free_mask_r[c_r] && !free_ok_r) free_r <= c_r;
    end
    if (finish_go) begin
      out_phys_r   <= res_phys;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.phys_reg = out_phys_r;
  assign out_ch.status   = out_status_r;

endmodule

// ===== rtl/core/rma_checker.sv =====
// rma_checker: port-level checks on the register map allocator, bound to the top level
// depends on rma_pkg for status codes and widths
module rma_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rma_pkg::PHYS_W-1:0] out_phys_reg,
  input logic [rma_pkg::STAT_W-1:0] out_status
);
  import rma_pkg::*;

  // a failed request never names a register
  a_fail_phys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_phys_reg == '0))
    else $error("nonzero phys_reg with failing status");

  // one word at a time: input closes right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accepting a word");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phys_reg) && $stable(out_status))
    else $error("result word changed while stalled");

endmodule

bind register_map_allocator rma_checker u_rma_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_phys_reg (out_ch.phys_reg),
  .out_status   (out_ch.status)
);

// ===== test/tb_register_map_allocator.sv =====
// tb_register_map_allocator: self-checking bench for the register map allocator
// drives request words and count writes, predicts every result word and checks it
// depends on rma_pkg, rma_if and the register_map_allocator rtl
`timescale 1ns / 100ps

module tb_register_map_allocator;
  import rma_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_WORDS   = 600;
  localparam int PHASE_WORDS    = 50;
  localparam logic [CFG_IW-1:0] REG_IDX_UNUSED = 1'b1;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic [STAT_W-1:0] status;
  } rename_result_t;

  logic clk;
  logic rst_n;

  rma_in_if  in_ch ();
  rma_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  register_map_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the rename map
  logic [COUNT_W-1:0] count_reg;
  logic               map_used [MAX_REGS];
  logic [VREG_W-1:0]  map_vreg [MAX_REGS];
  logic [PHYS_W-1:0]  map_phys [MAX_REGS];
  logic [MASK_W-1:0]  free_regs;

  rename_result_t pending_results[$];
  int  errors;
  int  quiet_cycles;
  bit  steady;
  bit  hold_request;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // number of physical registers and map entries actually in use
  function automatic int regs_in_use();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_REGS) n = MAX_REGS;
    return n;
  endfunction

  // empty the map and free the low registers
  function automatic void clear_rename_map();
    int n;
    n = regs_in_use();
    for (int i = 0; i < MAX_REGS; i++) map_used[i] = 1'b0;
    free_regs = '0;
    for (int i = 0; i < n; i++) free_regs[i] = 1'b1;
  endfunction

  // apply one request word to the shadow map and return its result
  function automatic rename_result_t rename_lookup(input logic [OP_W-1:0] op,
                                                   input logic [VREG_W-1:0] vreg);
    rename_result_t r;
    int n, hit, slot, preg;
    n = regs_in_use();
    hit = -1;
    slot = -1;
    preg = -1;
    r = '0;
    r.status = ST_OK;
    for (int i = 0; i < n; i++)
      if (hit < 0 && map_used[i] && map_vreg[i] == vreg) hit = i;
    if (op == OP_ALLOC) begin
      if (hit >= 0) begin
        r.phys = map_phys[hit];
      end else begin
        for (int i = 0; i < n; i++)
          if (slot < 0 && !map_used[i]) slot = i;
        for (int i = 0; i < MASK_W; i++)
          if (preg < 0 && free_regs[i]) preg = i;
        if (preg < 0 || slot < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          free_regs[preg] = 1'b0;
          map_used[slot] = 1'b1;
          map_vreg[slot] = vreg;
          map_phys[slot] = PHYS_W'(preg);
          r.phys = PHYS_W'(preg);
        end
      end
    end else if (hit >= 0) begin
      r.phys = map_phys[hit];
      free_regs[r.phys] = 1'b1;
      map_used[hit] = 1'b0;
    end else begin
      r.status = ST_NOT_MAPPED;
    end
    return r;
  endfunction

  // send one request word and record its expected result
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VREG_W-1:0] vreg);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.vreg_num <= vreg;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(rename_lookup(op, vreg));
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // apb write, then read back the count register
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    logic [CFG_DW-1:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_IDX_COUNT) begin
      count_reg = data[COUNT_W-1:0];
      clear_rename_map();
    end
    // read phase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {REG_IDX_COUNT, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = CFG_DW'(count_reg);
    if (cfg_prdata !== want) begin
      $error("count readback: expected %0d, got %0d", want, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // count write with random upper bits, which the register drops
  task automatic set_count(input int value);
    logic [CFG_DW-1:0] data;
    data = $urandom();
    data[COUNT_W-1:0] = COUNT_W'(value);
    write_reg(REG_IDX_COUNT, data);
  endtask

  // map, hit, release and miss at the default count
  task automatic test_basic_map();
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_FREE,  32'hFFFF_FFFF);
    send_request(OP_FREE,  32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'h5555_5555);
    send_request(OP_FREE,  32'h0000_0000);
    send_request(OP_ALLOC, 32'hAAAA_AAAA);
    drain();
  endtask

  // exhausted pool: hits still succeed, misses fail until a release
  task automatic test_pool_exhaustion();
    set_count(2);
    send_request(OP_ALLOC, 32'h0000_0011);
    send_request(OP_ALLOC, 32'h8000_0022);
    send_request(OP_ALLOC, 32'h0000_0033);
    send_request(OP_ALLOC, 32'h0000_0011);
    send_request(OP_FREE,  32'h8000_0022);
    send_request(OP_ALLOC, 32'h0000_0033);
    drain();
  endtask

  // count of zero reads as one, counts above the pool clamp to the pool
  task automatic test_count_limits();
    set_count(0);
    send_request(OP_ALLOC, 32'h1234_5678);
    send_request(OP_ALLOC, 32'h8765_4321);
    send_request(OP_FREE,  32'h8765_4321);
    send_request(OP_FREE,  32'h1234_5678);
    drain();
    set_count(63);
    send_request(OP_ALLOC, 32'hDEAD_BEEF);
    send_request(OP_ALLOC, 32'h0BAD_F00D);
    drain();
    set_count(33);
    send_request(OP_ALLOC, 32'hCAFE_0001);
    drain();
  endtask

  // a write to an unused register index leaves the map alone
  task automatic test_unused_index();
    set_count(3);
    send_request(OP_ALLOC, 32'h0000_0042);
    drain();
    write_reg(REG_IDX_UNUSED, 32'h0000_0001);
    send_request(OP_ALLOC, 32'h0000_0042);
    send_request(OP_ALLOC, 32'h7FFF_FFFF);
    drain();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_count(32);
    hold_request = 1'b1;
    send_request(OP_ALLOC, $urandom());
    steady = 1'b1;
    for (int i = 0; i < 16; i++) send_request(i % 4 == 3 ? OP_FREE : OP_ALLOC, $urandom());
    steady = 1'b0;
    drain();
  endtask

  // phases of random traffic, each at its own count, over a small set of names
  task automatic test_random_traffic();
    int sent, phase, n, cnt;
    logic [VREG_W-1:0] names[$];
    logic [VREG_W-1:0] vreg;
    logic [OP_W-1:0] op;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: cnt = 1;
        1: cnt = 32;
        2: cnt = 0;
        3: cnt = 63;
        4: cnt = 33;
        default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(1, 8);
      endcase
      set_count(cnt);
      n = regs_in_use();
      names.delete();
      for (int i = 0; i < n + 3; i++) names.push_back($urandom());
      if ($urandom_range(0, 1) != 0) names[0] = '1;
      else names[0] = '0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        op = ($urandom_range(0, 99) < 60) ? OP_ALLOC : OP_FREE;
        if ($urandom_range(0, 9) == 0) vreg = $urandom();
        else vreg = names[$urandom_range(0, names.size() - 1)];
        send_request(op, vreg);
        sent++;
      end
      steady = 1'b0;
      drain();
      phase++;
    end
  endtask

  // main sequence
  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_ALLOC;
    in_ch.vreg_num <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    errors = 0;
    steady = 1'b0;
    hold_request = 1'b0;
    count_reg = COUNT_W'(MAX_REGS);
    clear_rename_map();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_map();
    test_pool_exhaustion();
    test_count_limits();
    test_unused_index();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    rename_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: phys_reg %0d status %0d",
               out_ch.phys_reg, out_ch.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.phys_reg !== want.phys) begin
          $error("phys_reg: expected %0d, got %0d", want.phys, out_ch.phys_reg);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
